@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/csf_pkg.sv @@
// Types, step codes, corner table and step helpers for the contour shape unit.
// No dependencies.
`default_nettype none

package csf_pkg;

   localparam int COORD_BITS = 12;
   localparam int COUNT_BITS = 16;
   localparam int AREA_BITS  = 29;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic signed [AREA_BITS-1:0]  area_type;

   localparam area_type HALF_ROW = area_type'(4);

   // direction of one step between successive points
   typedef enum logic [3:0] {
      CODE_NONE       = 4'd0,
      CODE_LEFT_UP    = 4'd1,
      CODE_LEFT       = 4'd2,
      CODE_LEFT_DOWN  = 4'd3,
      CODE_DOWN       = 4'd4,
      CODE_RIGHT_DOWN = 4'd5,
      CODE_RIGHT      = 4'd6,
      CODE_RIGHT_UP   = 4'd7,
      CODE_UP         = 4'd8
   } step_code_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last_point;
   } req_word_type;

   typedef struct packed {
      area_type  area_eighths;
      count_type straight_steps;
      count_type diagonal_steps;
      coord_type min_x;
      coord_type max_x;
      coord_type min_y;
      coord_type max_y;
      logic      zero_step_error;
   } rsp_word_type;

   typedef struct packed {
      step_code_type code;
      area_type      term;
      logic          diagonal;
      logic          zero;
   } step_type;

   localparam logic [3:0] CORNER_TAB [0:8][0:8] = '{
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3},
      '{4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0},
      '{4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
      '{4'd0, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
      '{4'd0, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6},
      '{4'd0, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5},
      '{4'd0, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4}
   };

   function automatic area_type corner_value(input step_code_type a, input step_code_type b);
      area_type v;
      v = '0;
      if (a <= CODE_UP && b <= CODE_UP) begin
         v = area_type'(CORNER_TAB[a][b]);
      end
      return v;
   endfunction

   // code and strip term of step (px,py)->(cx,cy); strip at cy, half a row toward py
   function automatic step_type step_eval(input coord_type px, input coord_type py,
                                          input coord_type cx, input coord_type cy);
      step_type s;
      area_type t;
      t = area_type'({cy, 3'b000});
      if (cy > py) begin
         t = t - HALF_ROW;
      end else if (cy < py) begin
         t = t + HALF_ROW;
      end
      s.diagonal = (cx != px) && (cy != py);
      s.zero     = (cx == px) && (cy == py);
      s.term     = '0;
      if (cx > px) begin
         s.term = t;
         if (cy > py)      s.code = CODE_RIGHT_DOWN;
         else if (cy < py) s.code = CODE_RIGHT_UP;
         else              s.code = CODE_RIGHT;
      end else if (cx < px) begin
         s.term = -t;
         if (cy > py)      s.code = CODE_LEFT_DOWN;
         else if (cy < py) s.code = CODE_LEFT_UP;
         else              s.code = CODE_LEFT;
      end else begin
         if (cy > py)      s.code = CODE_DOWN;
         else if (cy < py) s.code = CODE_UP;
         else              s.code = CODE_NONE;
      end
      return s;
   endfunction

   // saturating add of up to two unit increments
   function automatic count_type count_add(input count_type c, input logic inc_a,
                                           input logic inc_b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, c} + (COUNT_BITS+1)'(inc_a) + (COUNT_BITS+1)'(inc_b);
      return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/contour_shape_features_unit.sv @@
// Contour shape unit: area, step counts and bounding box of a closed contour.
// Depends on csf_pkg and assert_macros.svh.
`default_nettype none

// Takes one boundary point per cycle on req_ while req_ready is high, with last_point
// set on the final point of a contour, and gives one word on rsp_ per contour: signed
// area in eighths, straight and diagonal step counts (closing step included,
// saturating), bounding box and a zero-step error flag (area reads 0 when set).
// A point goes into an input register and is folded into the running sums when it
// leaves it; at that same edge the result word of a last point lands in the output
// register, which drives rsp_valid. A non-last point never waits in the input
// register; a last point waits there only while the previous result word is not
// yet taken, and req_ready is low meanwhile.
`include "assert_macros.svh"

module contour_shape_features_unit
   import csf_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_word_type rsp_data
);

   req_word_type  in_ff, in_in;
   logic          in_v_ff, in_v_in;
   rsp_word_type  out_ff, out_in;
   logic          out_v_ff, out_v_in;

   coord_type     first_x_ff, first_x_in, first_y_ff, first_y_in;
   coord_type     prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   step_code_type first_code_ff, first_code_in, prev_code_ff, prev_code_in;
   logic [1:0]    points_ff, points_in;
   area_type      area_ff, area_in;
   count_type     straight_ff, straight_in, diagonal_ff, diagonal_in;
   coord_type     min_x_ff, min_x_in, max_x_ff, max_x_in;
   coord_type     min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic          error_ff, error_in;

   logic          adv;
   step_type      step_a, step_b;
   logic          has_a;
   coord_type     fx, fy;
   step_code_type fcode, pcode;
   logic [1:0]    points_nx;
   area_type      area_a, area_b;
   count_type     straight_a, diagonal_a;
   logic          err_a;

   assign adv       = in_v_ff && (!in_ff.last_point || !out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || adv;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      has_a  = (points_ff != 2'd0);
      step_a = step_eval(prev_x_ff, prev_y_ff, in_ff.x, in_ff.y);
      fx     = has_a ? first_x_ff : in_ff.x;
      fy     = has_a ? first_y_ff : in_ff.y;
      step_b = step_eval(in_ff.x, in_ff.y, fx, fy);

      points_nx = has_a ? 2'd2 : 2'd1;
      fcode     = (points_ff == 2'd1) ? step_a.code : first_code_ff;
      pcode     = has_a ? step_a.code : prev_code_ff;

      area_a     = area_ff;
      straight_a = straight_ff;
      diagonal_a = diagonal_ff;
      err_a      = error_ff;
      min_x_in   = in_ff.x;
      max_x_in   = in_ff.x;
      min_y_in   = in_ff.y;
      max_y_in   = in_ff.y;
      if (has_a) begin
         area_a = area_ff + step_a.term;
         if (points_ff == 2'd2) begin
            area_a = area_a + corner_value(prev_code_ff, step_a.code);
         end
         err_a    = error_ff || step_a.zero;
         min_x_in = (in_ff.x < min_x_ff) ? in_ff.x : min_x_ff;
         max_x_in = (in_ff.x > max_x_ff) ? in_ff.x : max_x_ff;
         min_y_in = (in_ff.y < min_y_ff) ? in_ff.y : min_y_ff;
         max_y_in = (in_ff.y > max_y_ff) ? in_ff.y : max_y_ff;
      end

      area_b = area_a + step_b.term;
      if (points_nx == 2'd2) begin
         area_b = area_b + corner_value(pcode, step_b.code) + corner_value(step_b.code, fcode);
      end

      straight_a = count_add(straight_ff, has_a && !step_a.diagonal, 1'b0);
      diagonal_a = count_add(diagonal_ff, has_a && step_a.diagonal, 1'b0);

      out_in.straight_steps  = count_add(straight_a, !step_b.diagonal, 1'b0);
      out_in.diagonal_steps  = count_add(diagonal_a, step_b.diagonal, 1'b0);
      out_in.zero_step_error = err_a || step_b.zero;
      out_in.area_eighths    = out_in.zero_step_error ? area_type'(0) : area_b;
      out_in.min_x           = min_x_in;
      out_in.max_x           = max_x_in;
      out_in.min_y           = min_y_in;
      out_in.max_y           = max_y_in;

      first_x_in    = fx;
      first_y_in    = fy;
      prev_x_in     = in_ff.x;
      prev_y_in     = in_ff.y;
      first_code_in = fcode;
      prev_code_in  = pcode;
      points_in     = in_ff.last_point ? 2'd0 : points_nx;
      area_in       = in_ff.last_point ? area_type'(0) : area_a;
      straight_in   = in_ff.last_point ? count_type'(0) : straight_a;
      diagonal_in   = in_ff.last_point ? count_type'(0) : diagonal_a;
      error_in      = in_ff.last_point ? 1'b0 : err_a;

      in_in    = req_data;
      in_v_in  = req_valid || (in_v_ff && !adv);
      out_v_in = (adv && in_ff.last_point) || (out_v_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
         points_ff     <= 2'd0;
         area_ff       <= '0;
         straight_ff   <= '0;
         diagonal_ff   <= '0;
         error_ff      <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         first_code_ff <= CODE_NONE;
         prev_code_ff  <= CODE_NONE;
         min_x_ff      <= '0;
         max_x_ff      <= '0;
         min_y_ff      <= '0;
         max_y_ff      <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         if (adv) begin
            points_ff     <= points_in;
            area_ff       <= area_in;
            straight_ff   <= straight_in;
            diagonal_ff   <= diagonal_in;
            error_ff      <= error_in;
            first_x_ff    <= first_x_in;
            first_y_ff    <= first_y_in;
            prev_x_ff     <= prev_x_in;
            prev_y_ff     <= prev_y_in;
            first_code_ff <= first_code_in;
            prev_code_ff  <= prev_code_in;
            min_x_ff      <= min_x_in;
            max_x_ff      <= max_x_in;
            min_y_ff      <= min_y_in;
            max_y_ff      <= max_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ff <= in_in;
      end
      if (adv && in_ff.last_point) begin
         out_ff <= out_in;
      end
   end

   `ASSERT_IMPLY(a_rsp_from_last, clock, reset, $rose(out_v_ff),
      $past(adv && in_ff.last_point), "result word without a last point")
   `ASSERT_IMPLY(a_err_zero_area, clock, reset, out_v_ff && out_ff.zero_step_error,
      out_ff.area_eighths == area_type'(0), "area not cleared on zero step")
   `ASSERT_IMPLY(a_box_order, clock, reset, points_ff != 2'd0,
      (min_x_ff <= max_x_ff) && (min_y_ff <= max_y_ff), "bounding box out of order")
   `ASSERT_CLK(a_points_range, clock, reset, points_ff != 2'd3, "point counter out of range")
   `ASSERT_IMPLY(a_restart, clock, reset, adv && in_ff.last_point,
      ##1 (points_ff == 2'd0), "state not cleared after result")

endmodule

`default_nettype wire
